### src/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger: field widths,
// operation and register codes, reset values and the sound-speed scale.
// ----------------------------------------------------------------------------
package uer_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int MS_W       = 32;
    localparam int CFG_W      = 16;
    localparam int DIST_W     = 11;
    localparam int CFG_IDX_W  = 3;

    // default microsecond timer width
    localparam int US_TIMER_WIDTH = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST      = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0]  RST_TRIG_INTERVAL = 16'd60;
    localparam logic [CFG_W-1:0]  RST_ECHO_TIMEOUT  = 16'd30;
    localparam logic [CFG_W-1:0]  RST_STALE_LIMIT   = 16'd250;
    localparam logic [DIST_W-1:0] RST_MIN_DIST      = 11'd2;
    localparam logic [DIST_W-1:0] RST_MAX_DIST      = 11'd400;

    // distance = pulse_us * SOUND_NUM / SOUND_DEN
    localparam longint unsigned SOUND_NUM = 343;
    localparam longint unsigned SOUND_DEN = 20000;
    // bits that cover SOUND_DEN, sets the reciprocal precision
    localparam int SOUND_DEN_BITS = 15;

    // one gated reading
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              valid;
    } t_reading;

endpackage

### src/uer_ifs.sv
// ----------------------------------------------------------------------------
// uer_ifs
// Valid/ready channels of the ultrasonic echo ranger: event input, result
// output and register write port.
// ----------------------------------------------------------------------------

// event channel
interface uer_evt_if #(
    parameter int TW = uer_pkg::US_TIMER_WIDTH
);
    logic                       valid;
    logic                       ready;
    logic [uer_pkg::OP_W-1:0]   op;
    logic [uer_pkg::MS_W-1:0]   now_ms;
    logic [TW-1:0]              timer_us;
    logic                       echo_level;

    modport source (output valid, op, now_ms, timer_us, echo_level, input ready);
    modport sink   (input valid, op, now_ms, timer_us, echo_level, output ready);
endinterface

// result channel
interface uer_res_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger_start;
    logic [uer_pkg::DIST_W-1:0] range_cm;
    logic                       reading_valid;
    logic                       measuring;

    modport source (output valid, trigger_start, range_cm, reading_valid, measuring,
                    input ready);
    modport sink   (input valid, trigger_start, range_cm, reading_valid, measuring,
                    output ready);
endinterface

// register write channel
interface uer_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [uer_pkg::CFG_IDX_W-1:0] index;
    logic [uer_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/uer_range_calc.sv
// ----------------------------------------------------------------------------
// uer_range_calc
// Turns an echo pulse length in microseconds into centimetres and gates it
// by the minimum and maximum distance.
// ----------------------------------------------------------------------------
module uer_range_calc #(
    parameter int TW = uer_pkg::US_TIMER_WIDTH
) (
    input  logic [TW-1:0]              i_pulse_us,
    input  logic [uer_pkg::DIST_W-1:0] i_min_cm,
    input  logic [uer_pkg::DIST_W-1:0] i_max_cm,
    output uer_pkg::t_reading          o_reading
);
    // floor(n * 343 / 20000) as (n * RECIP) >> SHIFT, exact for n < 2^TW
    localparam int              SHIFT = TW + uer_pkg::SOUND_DEN_BITS;
    localparam longint unsigned RECIP =
        ((uer_pkg::SOUND_NUM << SHIFT) + uer_pkg::SOUND_DEN - 1) / uer_pkg::SOUND_DEN;
    localparam int              KW    = $clog2(RECIP + 1);
    localparam int              PW    = TW + KW;
    localparam int              DW    = PW - SHIFT;
    localparam int              CW    = (DW > uer_pkg::DIST_W) ? DW : uer_pkg::DIST_W;

    logic [PW-1:0] prod;
    logic [CW-1:0] calc_cm;
    logic [CW-1:0] min_ext;
    logic [CW-1:0] max_ext;
    logic          in_range;

    // constant multiply by the scaled reciprocal
    assign prod     = PW'(i_pulse_us) * PW'(RECIP);
    assign calc_cm  = CW'(prod[PW-1:SHIFT]);
    assign min_ext  = CW'(i_min_cm);
    assign max_ext  = CW'(i_max_cm);

    // range gate
    assign in_range = (calc_cm >= min_ext) && (calc_cm <= max_ext);

    assign o_reading.valid    = in_range;
    assign o_reading.distance = in_range ? calc_cm[uer_pkg::DIST_W-1:0] : '0;

endmodule

### src/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Trigger scheduling, echo timing and distance reporting for an ultrasonic
// range sensor.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event word: a millisecond tick, an echo pin edge with
//   its microsecond stamp, or a plain read. Every accepted word yields one
//   result word on o_res: trigger_start (this tick begins a trigger pulse,
//   the 10 us pulse itself is generated by the pin logic), the latest
//   distance and valid bit (zero once older than the stale limit) and the
//   measuring flag after the update.
//   i_cfg writes the five registers by index; unknown indexes are dropped.
//   Writes only while no event is in flight: the block does not enforce it.
//   An accepted word passes through the input register, then the result
//   register. Throughput is one word per cycle while the receiver takes
//   results; the state update plus the constant multiply of the pulse length
//   sit in the single stage between the two registers.
//   Reset puts the registers at their defaults and the ranger idle with no
//   reading. When the receiver stalls, the result register holds and the
//   input register fills; i_evt.ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit #(
    parameter int US_TIMER_WIDTH = uer_pkg::US_TIMER_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uer_evt_if.sink     i_evt,
    uer_cfg_if.sink     i_cfg,
    uer_res_if.source   o_res
);
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RISE,
        PH_FALL
    } t_phase;

    // configuration
    logic [uer_pkg::CFG_W-1:0]  r_trig_interval;
    logic [uer_pkg::CFG_W-1:0]  r_echo_timeout;
    logic [uer_pkg::CFG_W-1:0]  r_stale_limit;
    logic [uer_pkg::DIST_W-1:0] r_min_dist;
    logic [uer_pkg::DIST_W-1:0] r_max_dist;

    // input register
    logic                       r_s1_vld;
    logic [uer_pkg::OP_W-1:0]   r_s1_op;
    logic [uer_pkg::MS_W-1:0]   r_s1_now;
    logic [US_TIMER_WIDTH-1:0]  r_s1_us;
    logic                       r_s1_lvl;

    // ranger state
    t_phase                     r_phase,     n_phase;
    logic [US_TIMER_WIDTH-1:0]  r_start_us,  n_start_us;
    logic [uer_pkg::DIST_W-1:0] r_dist,      n_dist;
    logic                       r_valid,     n_valid;
    logic [uer_pkg::MS_W-1:0]   r_res_time,  n_res_time;
    logic [uer_pkg::MS_W-1:0]   r_trig_time, n_trig_time;
    logic                       n_trig;

    // result register
    logic                       r_out_vld;
    logic                       r_out_trig;
    logic [uer_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_rv;
    logic                       r_out_meas;

    logic                       out_free;
    logic                       advance;
    logic [uer_pkg::MS_W-1:0]   since_trig;
    logic [uer_pkg::MS_W-1:0]   since_res;
    logic                       timed_out;
    logic                       stale;
    logic [US_TIMER_WIDTH-1:0]  pulse_us;
    uer_pkg::t_reading          reading;

    // handshakes
    assign out_free    = !r_out_vld || o_res.ready;
    assign advance     = r_s1_vld && out_free;
    assign i_evt.ready = !r_s1_vld || out_free;
    assign i_cfg.ready = 1'b1;

    // pulse length wraps with the timer
    assign pulse_us = r_s1_us - r_start_us;

    uer_range_calc #(
        .TW (US_TIMER_WIDTH)
    ) u_range_calc (
        .i_pulse_us (pulse_us),
        .i_min_cm   (r_min_dist),
        .i_max_cm   (r_max_dist),
        .o_reading  (reading)
    );

    // next state for the item in the input register
    always_comb begin
        n_phase     = r_phase;
        n_start_us  = r_start_us;
        n_dist      = r_dist;
        n_valid     = r_valid;
        n_res_time  = r_res_time;
        n_trig_time = r_trig_time;
        n_trig      = 1'b0;
        since_trig  = r_s1_now - r_trig_time;
        timed_out   = (r_phase != PH_IDLE) &&
                      (since_trig >= uer_pkg::MS_W'(r_echo_timeout));
        unique case (r_s1_op)
            uer_pkg::OP_TICK: begin
                // abandon a pending measurement, then maybe start a trigger
                if (timed_out) begin
                    n_dist     = '0;
                    n_valid    = 1'b0;
                    n_res_time = r_s1_now;
                    n_phase    = PH_IDLE;
                end
                if ((r_phase == PH_IDLE || timed_out) &&
                    (since_trig >= uer_pkg::MS_W'(r_trig_interval))) begin
                    n_trig_time = r_s1_now;
                    n_phase     = PH_RISE;
                    n_trig      = 1'b1;
                end
            end
            uer_pkg::OP_EDGE: begin
                priority if (r_phase == PH_RISE && r_s1_lvl) begin
                    n_start_us = r_s1_us;
                    n_phase    = PH_FALL;
                end else if (r_phase == PH_FALL && !r_s1_lvl) begin
                    n_dist     = reading.distance;
                    n_valid    = reading.valid;
                    n_res_time = r_s1_now;
                    n_phase    = PH_IDLE;
                end else begin
                    n_phase    = r_phase;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        since_res = r_s1_now - n_res_time;
        stale     = since_res > uer_pkg::MS_W'(r_stale_limit);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_interval <= uer_pkg::RST_TRIG_INTERVAL;
            r_echo_timeout  <= uer_pkg::RST_ECHO_TIMEOUT;
            r_stale_limit   <= uer_pkg::RST_STALE_LIMIT;
            r_min_dist      <= uer_pkg::RST_MIN_DIST;
            r_max_dist      <= uer_pkg::RST_MAX_DIST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                uer_pkg::REG_TRIG_INTERVAL: r_trig_interval <= i_cfg.data;
                uer_pkg::REG_ECHO_TIMEOUT:  r_echo_timeout  <= i_cfg.data;
                uer_pkg::REG_STALE_LIMIT:   r_stale_limit   <= i_cfg.data;
                uer_pkg::REG_MIN_DIST:      r_min_dist <= i_cfg.data[uer_pkg::DIST_W-1:0];
                uer_pkg::REG_MAX_DIST:      r_max_dist <= i_cfg.data[uer_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_evt.ready) begin
            r_s1_vld <= i_evt.valid;
        end
        if (i_evt.valid && i_evt.ready) begin
            r_s1_op  <= i_evt.op;
            r_s1_now <= i_evt.now_ms;
            r_s1_us  <= i_evt.timer_us;
            r_s1_lvl <= i_evt.echo_level;
        end
    end

    // ranger state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_start_us  <= '0;
            r_dist      <= '0;
            r_valid     <= 1'b0;
            r_res_time  <= '0;
            r_trig_time <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
            if (advance) begin
                r_phase     <= n_phase;
                r_start_us  <= n_start_us;
                r_dist      <= n_dist;
                r_valid     <= n_valid;
                r_res_time  <= n_res_time;
                r_trig_time <= n_trig_time;
            end
        end
        if (advance) begin
            r_out_trig <= n_trig;
            r_out_dist <= stale ? '0 : n_dist;
            r_out_rv   <= stale ? 1'b0 : n_valid;
            r_out_meas <= (n_phase != PH_IDLE);
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.trigger_start = r_out_trig;
    assign o_res.range_cm      = r_out_dist;
    assign o_res.reading_valid = r_out_rv;
    assign o_res.measuring     = r_out_meas;

endmodule
